@@ rtl/core/fdccr_pkg.sv @@
// ----------------------------------------------------------------------------
// fdccr_pkg
// Shared constants and types for the floppy command/result controller.
// ----------------------------------------------------------------------------
package fdccr_pkg;

   localparam int SECTORS_PER_TRACK = 9;
   localparam int TRACK_STRIDE      = 4864;
   localparam int SECTOR_BYTES      = 512;
   localparam int PAYLOAD_START     = 512;
   localparam int HEADER_BYTES      = 7;
   localparam int OFFSET_W          = 21;
   localparam int POS_W             = $clog2(HEADER_BYTES + SECTOR_BYTES + 1);
   localparam int HDR_IDX_W         = $clog2(HEADER_BYTES);

   // access kinds
   localparam logic [1:0] ACC_DATA_WRITE  = 2'd0;
   localparam logic [1:0] ACC_DATA_READ   = 2'd1;
   localparam logic [1:0] ACC_STATUS_READ = 2'd2;

   // command opcodes as written on the bus
   localparam logic [7:0] OPC_SPECIFY     = 8'h03;
   localparam logic [7:0] OPC_SENSE_DRIVE = 8'h04;
   localparam logic [7:0] OPC_RECAL       = 8'h07;
   localparam logic [7:0] OPC_SENSE_INT   = 8'h08;
   localparam logic [3:0] OPC_READ_ID_LO  = 4'hA;
   localparam logic [3:0] OPC_READ_DATA_LO = 4'h6;
   localparam logic [7:0] OPC_SEEK        = 8'h0F;

   // main status bits
   localparam logic [7:0] MS_RQM  = 8'h80;
   localparam logic [7:0] MS_DIO  = 8'h40;
   localparam logic [7:0] MS_BUSY = 8'h10;
   localparam logic [7:0] MS_KEEP = 8'h0F;

   // status register bits
   localparam logic [7:0] ST_SEEK_END  = 8'h20;
   localparam logic [7:0] ST_ABNORMAL  = 8'h40;
   localparam logic [7:0] ST_INVALID   = 8'h80;
   localparam logic [7:0] ST3_TRACK0   = 8'h20;
   localparam logic [7:0] READ_INVALID = 8'hFF;

   typedef enum logic [2:0] {
      CMD_SPECIFY     = 3'd0,
      CMD_SENSE_DRIVE = 3'd1,
      CMD_RECAL       = 3'd2,
      CMD_SENSE_INT   = 3'd3,
      CMD_READ_ID     = 3'd4,
      CMD_READ_DATA   = 3'd5,
      CMD_SEEK        = 3'd6,
      CMD_NONE        = 3'd7
   } command_type;

endpackage

@@ rtl/core/fdc_command_result_controller_unit.sv @@
// ----------------------------------------------------------------------------
// fdc_command_result_controller_unit
// Register model of a simplified floppy controller data/status port.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel is one bus access: tuser carries the
//   access kind (data write, data read, status read), tdata the written byte.
//   Every request yields exactly one response on the rsp_ channel: the read
//   byte in tdata, plus a disk image offset when tuser (from_disk) is set, in
//   which case the byte must be fetched from external memory.
//   Controller state is updated in the accepting cycle; the response sits in
//   an output register and appears in the cycle after the request is accepted.
//   Throughput is one request per cycle, limited only by the output register:
//   req_tready stays high while the response register is empty or is being
//   drained in the same cycle.
//   When the receiver stalls, the pending response holds and req_tready drops
//   until it is taken.
//   Synchronous reset returns the controller to idle with main status 0x80
//   and no response pending; the result byte store is not cleared.
// ----------------------------------------------------------------------------
module fdc_command_result_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] write_byte
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] read_byte, [28:8] disk_offset
   output logic        rsp_tuser    // [0] from_disk
);
   import fdccr_pkg::*;

   logic [3:0]          param_index_ff, param_index_in;
   command_type         current_command_ff, current_command_in;
   logic [7:0]          main_status_ff, main_status_in;
   logic [1:0]          unit_select_ff, unit_select_in;
   logic [7:0]          head_value_ff, head_value_in;
   logic [7:0]          new_cylinder_ff, new_cylinder_in;
   logic [7:0]          present_cylinder_ff, present_cylinder_in;
   logic [7:0]          sector_number_ff, sector_number_in;
   logic [7:0]          size_code_ff, size_code_in;
   logic [7:0]          status_zero_ff, status_zero_in;
   logic [7:0]          status_three_ff, status_three_in;
   logic                op_pending_ff, op_pending_in;
   logic [15:0]         timing_settings_ff, timing_settings_in;
   logic [23:0]         read_params_ff, read_params_in;
   logic [7:0]          result_bytes_ff [HEADER_BYTES];
   logic [7:0]          result_bytes_in [HEADER_BYTES];
   logic [POS_W-1:0]    result_remaining_ff, result_remaining_in;
   logic [POS_W-1:0]    result_pos_ff, result_pos_in;
   logic                in_result_ff, in_result_in;
   logic [OFFSET_W-1:0] payload_base_ff, payload_base_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_disk_ff, rsp_disk_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   logic       req_accept;
   logic [1:0] acc_kind;
   logic [7:0] wbyte;
   logic [3:0] idx;
   logic [7:0] sector_inc;
   logic [7:0] hdr_seek;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign acc_kind   = req_tuser;
   assign wbyte      = req_tdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_offset_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_disk_ff;

   assign sector_inc = sector_number_ff + 8'd1;
   assign hdr_seek   = {5'd0, head_value_ff[0], unit_select_ff} | ST_SEEK_END;

   always_comb begin
      param_index_in      = param_index_ff;
      current_command_in  = current_command_ff;
      main_status_in      = main_status_ff;
      unit_select_in      = unit_select_ff;
      head_value_in       = head_value_ff;
      new_cylinder_in     = new_cylinder_ff;
      present_cylinder_in = present_cylinder_ff;
      sector_number_in    = sector_number_ff;
      size_code_in        = size_code_ff;
      status_zero_in      = status_zero_ff;
      status_three_in     = status_three_ff;
      op_pending_in       = op_pending_ff;
      timing_settings_in  = timing_settings_ff;
      read_params_in      = read_params_ff;
      result_bytes_in     = result_bytes_ff;
      result_remaining_in = result_remaining_ff;
      result_pos_in       = result_pos_ff;
      in_result_in        = in_result_ff;
      payload_base_in     = payload_base_ff;
      rsp_byte_in         = 8'd0;
      rsp_disk_in         = 1'b0;
      rsp_offset_in       = '0;
      idx                 = param_index_ff + 4'd1;

      if (acc_kind == ACC_DATA_WRITE) begin
         if (param_index_ff == 4'd0) begin
            // command byte
            priority if (wbyte == OPC_SPECIFY) begin
               current_command_in = CMD_SPECIFY;
               param_index_in     = 4'd1;
               main_status_in     = (main_status_ff & MS_KEEP) | MS_RQM;
            end else if (wbyte == OPC_SENSE_DRIVE) begin
               current_command_in = CMD_SENSE_DRIVE;
               param_index_in     = 4'd1;
               main_status_in     = (main_status_ff & MS_KEEP) | MS_RQM;
            end else if (wbyte == OPC_RECAL) begin
               current_command_in = CMD_RECAL;
               param_index_in     = 4'd1;
               main_status_in     = (main_status_ff & MS_KEEP) | MS_RQM;
               op_pending_in      = 1'b1;
            end else if (wbyte == OPC_SENSE_INT) begin
               current_command_in  = CMD_SENSE_INT;
               param_index_in      = 4'd0;
               status_zero_in      = hdr_seek | (op_pending_ff ? 8'd0 : ST_INVALID);
               op_pending_in       = 1'b0;
               result_bytes_in[0]  = status_zero_in;
               result_bytes_in[1]  = present_cylinder_ff;
               result_remaining_in = POS_W'(2);
               result_pos_in       = '0;
               in_result_in        = 1'b1;
               main_status_in      = (main_status_ff & MS_KEEP) | MS_RQM | MS_DIO;
            end else if (wbyte[3:0] == OPC_READ_ID_LO) begin
               current_command_in = CMD_READ_ID;
               param_index_in     = 4'd1;
               status_zero_in     = hdr_seek | ST_ABNORMAL;
               status_three_in    = ST3_TRACK0;
               main_status_in     = (main_status_ff & MS_KEEP) | MS_RQM;
               op_pending_in      = 1'b1;
            end else if (wbyte[3:0] == OPC_READ_DATA_LO) begin
               current_command_in = CMD_READ_DATA;
               param_index_in     = 4'd1;
               main_status_in     = (main_status_ff & MS_KEEP) | MS_RQM;
               op_pending_in      = 1'b1;
            end else if (wbyte == OPC_SEEK) begin
               current_command_in = CMD_SEEK;
               param_index_in     = 4'd1;
               op_pending_in      = 1'b1;
            end else begin
               param_index_in = 4'd0;
            end
         end else begin
            // parameter byte
            unique case (current_command_ff)
               CMD_SPECIFY: begin
                  if (param_index_ff == 4'd1) timing_settings_in[15:8] = wbyte;
                  if (param_index_ff == 4'd2) timing_settings_in[7:0]  = wbyte;
                  param_index_in = idx;
                  if (idx >= 4'd3) begin
                     param_index_in = 4'd0;
                     main_status_in = (main_status_ff & MS_KEEP) | MS_RQM;
                  end
               end
               CMD_SENSE_DRIVE: begin
                  head_value_in  = {7'd0, wbyte[2]};
                  unit_select_in = wbyte[1:0];
                  param_index_in = 4'd0;
                  status_three_in     = (wbyte[1:0] != 2'd0) ? 8'd0 : ST3_TRACK0;
                  result_bytes_in[0]  = status_three_in;
                  result_remaining_in = POS_W'(1);
                  result_pos_in       = '0;
                  in_result_in        = 1'b1;
                  main_status_in = (main_status_ff & MS_KEEP) | MS_RQM | MS_DIO | MS_BUSY;
               end
               CMD_READ_DATA: begin
                  unique case (param_index_ff)
                     4'd1: begin
                        head_value_in  = {7'd0, wbyte[2]};
                        unit_select_in = wbyte[1:0];
                     end
                     4'd2: new_cylinder_in = wbyte;
                     4'd3: head_value_in = wbyte;
                     4'd4: sector_number_in = wbyte;
                     4'd5: size_code_in = wbyte;
                     4'd6: read_params_in[23:16] = wbyte;
                     4'd7: read_params_in[15:8] = wbyte;
                     4'd8: read_params_in[7:0] = wbyte;
                     default: ;
                  endcase
                  param_index_in = idx;
                  if (idx >= 4'd9) begin
                     param_index_in     = 4'd0;
                     status_zero_in     = hdr_seek;
                     result_bytes_in[0] = hdr_seek;
                     result_bytes_in[1] = 8'd0;
                     result_bytes_in[2] = 8'd0;
                     result_bytes_in[3] = new_cylinder_ff;
                     result_bytes_in[4] = head_value_ff;
                     result_bytes_in[5] = sector_number_ff;
                     result_bytes_in[6] = size_code_ff;
                     payload_base_in = OFFSET_W'(new_cylinder_ff) * OFFSET_W'(TRACK_STRIDE)
                                     + OFFSET_W'(sector_number_ff) * OFFSET_W'(SECTOR_BYTES)
                                     + OFFSET_W'(PAYLOAD_START);
                     // next sector, wrapping into the next track
                     if (sector_inc == 8'(SECTORS_PER_TRACK)) begin
                        sector_number_in = 8'd0;
                        new_cylinder_in  = new_cylinder_ff + 8'd1;
                     end else begin
                        sector_number_in = sector_inc;
                     end
                     result_remaining_in = POS_W'(HEADER_BYTES + SECTOR_BYTES);
                     result_pos_in       = '0;
                     in_result_in        = 1'b1;
                     main_status_in = (main_status_ff & MS_KEEP) | MS_RQM | MS_DIO | MS_BUSY;
                  end
               end
               CMD_RECAL: begin
                  unit_select_in      = wbyte[1:0];
                  new_cylinder_in     = 8'd0;
                  sector_number_in    = 8'd0;
                  param_index_in      = 4'd0;
                  present_cylinder_in = 8'd0;
                  status_zero_in      = {5'd0, head_value_ff[0], wbyte[1:0]} | ST_SEEK_END;
               end
               CMD_READ_ID: begin
                  head_value_in       = {7'd0, wbyte[2]};
                  unit_select_in      = wbyte[1:0];
                  param_index_in      = 4'd0;
                  status_zero_in      = {5'd0, wbyte[2:0]};
                  result_bytes_in[0]  = status_zero_in;
                  result_bytes_in[1]  = 8'd0;
                  result_bytes_in[2]  = 8'd0;
                  result_bytes_in[3]  = new_cylinder_ff;
                  result_bytes_in[4]  = {7'd0, wbyte[2]};
                  result_bytes_in[5]  = sector_number_ff;
                  result_bytes_in[6]  = size_code_ff;
                  result_remaining_in = POS_W'(HEADER_BYTES);
                  result_pos_in       = '0;
                  in_result_in        = 1'b1;
                  main_status_in = (main_status_ff & MS_KEEP) | MS_RQM | MS_DIO | MS_BUSY;
               end
               CMD_SEEK: begin
                  if (param_index_ff == 4'd1) begin
                     head_value_in  = {7'd0, wbyte[2]};
                     unit_select_in = wbyte[1:0];
                  end
                  param_index_in = idx;
                  if (param_index_ff == 4'd2) begin
                     new_cylinder_in     = wbyte;
                     sector_number_in    = 8'd0;
                     present_cylinder_in = wbyte;
                  end
                  if (idx >= 4'd3) begin
                     param_index_in = 4'd0;
                     status_zero_in = hdr_seek;
                  end
               end
               CMD_SENSE_INT, CMD_NONE: begin
                  param_index_in = param_index_ff;
               end
               default: ;
            endcase
         end
      end else if (acc_kind == ACC_DATA_READ) begin
         if (in_result_ff) begin
            if (result_remaining_ff != '0) begin
               result_remaining_in = result_remaining_ff - POS_W'(1);
            end
            if (result_remaining_in == '0) begin
               main_status_in = (main_status_ff & MS_KEEP) | MS_RQM;
               in_result_in   = 1'b0;
            end
            if (result_pos_ff < POS_W'(HEADER_BYTES)) begin
               rsp_byte_in = result_bytes_ff[result_pos_ff[HDR_IDX_W-1:0]];
            end else begin
               rsp_disk_in   = 1'b1;
               rsp_offset_in = payload_base_ff
                             + OFFSET_W'(result_pos_ff - POS_W'(HEADER_BYTES));
            end
            result_pos_in = result_pos_ff + POS_W'(1);
         end else begin
            rsp_byte_in = READ_INVALID;
         end
      end else if (acc_kind == ACC_STATUS_READ) begin
         rsp_byte_in = main_status_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         param_index_ff      <= 4'd0;
         current_command_ff  <= CMD_NONE;
         main_status_ff      <= MS_RQM;
         unit_select_ff      <= 2'd0;
         head_value_ff       <= 8'd0;
         new_cylinder_ff     <= 8'd0;
         present_cylinder_ff <= 8'd0;
         sector_number_ff    <= 8'd0;
         size_code_ff        <= 8'd2;
         status_zero_ff      <= 8'd0;
         status_three_ff     <= 8'd0;
         op_pending_ff       <= 1'b0;
         timing_settings_ff  <= 16'd0;
         read_params_ff      <= 24'd0;
         result_remaining_ff <= '0;
         result_pos_ff       <= '0;
         in_result_ff        <= 1'b0;
         payload_base_ff     <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            param_index_ff      <= param_index_in;
            current_command_ff  <= current_command_in;
            main_status_ff      <= main_status_in;
            unit_select_ff      <= unit_select_in;
            head_value_ff       <= head_value_in;
            new_cylinder_ff     <= new_cylinder_in;
            present_cylinder_ff <= present_cylinder_in;
            sector_number_ff    <= sector_number_in;
            size_code_ff        <= size_code_in;
            status_zero_ff      <= status_zero_in;
            status_three_ff     <= status_three_in;
            op_pending_ff       <= op_pending_in;
            timing_settings_ff  <= timing_settings_in;
            read_params_ff      <= read_params_in;
            result_remaining_ff <= result_remaining_in;
            result_pos_ff       <= result_pos_in;
            in_result_ff        <= in_result_in;
            payload_base_ff     <= payload_base_in;
         end
      end
   end

   // result store and response payload carry no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_bytes_ff <= result_bytes_in;
         rsp_byte_ff     <= rsp_byte_in;
         rsp_disk_ff     <= rsp_disk_in;
         rsp_offset_ff   <= rsp_offset_in;
      end
   end

   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      in_result_ff == (result_remaining_ff != '0))
      else $error("result phase flag disagrees with remaining count");

   a_status_low: assert property (@(posedge clock) disable iff (reset)
      main_status_ff[3:0] == 4'd0)
      else $error("main status low nibble set");

   a_param_range: assert property (@(posedge clock) disable iff (reset)
      param_index_ff <= 4'd8)
      else $error("parameter index out of range");

   a_disk_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_disk_ff |-> rsp_byte_ff == 8'd0)
      else $error("payload response carries a data byte");

endmodule

@@ bench/fdc_command_result_controller_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_command_result_controller_unit_checker
// Watches the request and response channels of the floppy controller, keeps
// its own copy of the controller state, predicts each response and compares.
// ----------------------------------------------------------------------------
module fdc_command_result_controller_unit_checker
   import fdccr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          error_count,
   output int          pending_count,
   output int          payload_reads,
   output int          header_reads
);

   typedef struct packed {
      logic [7:0]          read_byte;
      logic                from_disk;
      logic [OFFSET_W-1:0] disk_offset;
   } access_reply_type;

   access_reply_type reply_queue[$];

   logic [3:0]          param_idx;
   command_type         active_cmd;
   logic [7:0]          msr;
   logic [1:0]          unit;
   logic [7:0]          head;
   logic [7:0]          cyl_new;
   logic [7:0]          cyl_present;
   logic [7:0]          sector;
   logic [7:0]          size_n;
   logic [7:0]          st0;
   logic [7:0]          st3;
   logic                busy_op;
   logic [15:0]         timing;
   logic [23:0]         rd_params;
   logic [7:0]          hdr_bytes[7];
   int                  remaining;
   int                  rpos;
   logic                in_phase;
   logic [OFFSET_W-1:0] base_off;

   assign pending_count = reply_queue.size();

   function automatic logic [7:0] st0_now();
      return {5'b0, head[0], unit};
   endfunction

   function automatic logic [7:0] msr_set(logic [7:0] bits);
      return (msr & MS_KEEP) | bits;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic load_header();
      hdr_bytes[0] = st0;
      hdr_bytes[1] = 8'h00;
      hdr_bytes[2] = 8'h00;
      hdr_bytes[3] = cyl_new;
      hdr_bytes[4] = head;
      hdr_bytes[5] = sector;
      hdr_bytes[6] = size_n;
   endtask

   task automatic open_phase(int count);
      remaining = count;
      rpos      = 0;
      in_phase  = 1'b1;
   endtask

   task automatic start_command(logic [7:0] v);
      if (v == OPC_SPECIFY) begin
         active_cmd = CMD_SPECIFY; param_idx = 1; msr = msr_set(MS_RQM);
      end else if (v == OPC_SENSE_DRIVE) begin
         active_cmd = CMD_SENSE_DRIVE; param_idx = 1; msr = msr_set(MS_RQM);
      end else if (v == OPC_RECAL) begin
         active_cmd = CMD_RECAL; param_idx = 1; msr = msr_set(MS_RQM); busy_op = 1;
      end else if (v == OPC_SENSE_INT) begin
         active_cmd = CMD_SENSE_INT; param_idx = 0;
         st0 = st0_now() | ST_SEEK_END;
         if (!busy_op) st0 |= ST_INVALID;
         busy_op = 0;
         hdr_bytes[0] = st0;
         hdr_bytes[1] = cyl_present;
         open_phase(2);
         msr = msr_set(MS_RQM | MS_DIO);
      end else if (v[3:0] == OPC_READ_ID_LO) begin
         active_cmd = CMD_READ_ID; param_idx = 1;
         st0 = st0_now() | ST_SEEK_END | ST_ABNORMAL;
         st3 = ST3_TRACK0;
         msr = msr_set(MS_RQM); busy_op = 1;
      end else if (v[3:0] == OPC_READ_DATA_LO) begin
         active_cmd = CMD_READ_DATA; param_idx = 1; msr = msr_set(MS_RQM); busy_op = 1;
      end else if (v == OPC_SEEK) begin
         active_cmd = CMD_SEEK; param_idx = 1; busy_op = 1;
      end else begin
         param_idx = 0;
      end
   endtask

   task automatic take_param(logic [7:0] v);
      int idx;
      idx = param_idx;
      case (active_cmd)
         CMD_SPECIFY: begin
            if (idx == 1) timing[15:8] = v;
            if (idx == 2) timing[7:0] = v;
            idx++;
            if (idx >= 3) begin
               idx = 0; msr = msr_set(MS_RQM);
            end
         end
         CMD_SENSE_DRIVE: begin
            if (idx == 1) begin
               head = {7'b0, v[2]}; unit = v[1:0];
            end
            idx++;
            if (idx >= 2) begin
               idx = 0;
               st3 = (unit != 0) ? 8'h00 : ST3_TRACK0;
               hdr_bytes[0] = st3;
               open_phase(1);
               msr = msr_set(MS_RQM | MS_DIO | MS_BUSY);
            end
         end
         CMD_READ_DATA: begin
            case (idx)
               1: begin head = {7'b0, v[2]}; unit = v[1:0]; end
               2: cyl_new = v;
               3: head = v;
               4: sector = v;
               5: size_n = v;
               6: rd_params[23:16] = v;
               7: rd_params[15:8] = v;
               8: rd_params[7:0] = v;
               default: ;
            endcase
            idx++;
            if (idx >= 9) begin
               idx = 0;
               st0 = st0_now() | ST_SEEK_END;
               load_header();
               base_off = OFFSET_W'(int'(cyl_new) * TRACK_STRIDE
                                    + int'(sector) * SECTOR_BYTES + PAYLOAD_START);
               sector = sector + 8'd1;
               if (sector == SECTORS_PER_TRACK) begin
                  sector = 0; cyl_new = cyl_new + 8'd1;
               end
               open_phase(HEADER_BYTES + SECTOR_BYTES);
               msr = msr_set(MS_RQM | MS_DIO | MS_BUSY);
            end
         end
         CMD_RECAL: begin
            if (idx == 1) begin
               unit = v[1:0]; cyl_new = 0; sector = 0;
            end
            idx++;
            if (idx >= 2) begin
               idx = 0; cyl_present = 0; st0 = st0_now() | ST_SEEK_END;
            end
         end
         CMD_READ_ID: begin
            if (idx == 1) begin
               head = {7'b0, v[2]}; unit = v[1:0];
            end
            idx++;
            if (idx >= 2) begin
               idx = 0;
               st0 = st0_now();
               load_header();
               open_phase(HEADER_BYTES);
               msr = msr_set(MS_RQM | MS_DIO | MS_BUSY);
            end
         end
         CMD_SEEK: begin
            if (idx == 1) begin
               head = {7'b0, v[2]}; unit = v[1:0];
            end
            if (idx == 2) begin
               cyl_new = v; sector = 0; cyl_present = v;
            end
            idx++;
            if (idx >= 3) begin
               idx = 0; st0 = st0_now() | ST_SEEK_END;
            end
         end
         default: ;
      endcase
      param_idx = idx[3:0];
   endtask

   task automatic predict_access(logic [1:0] kind, logic [7:0] v);
      access_reply_type r;
      int p;
      r = '0;
      if (kind == ACC_DATA_WRITE) begin
         if (param_idx == 0) start_command(v);
         else take_param(v);
      end else if (kind == ACC_DATA_READ) begin
         if (in_phase) begin
            p = rpos;
            if (remaining > 0) remaining--;
            if (remaining == 0) begin
               msr = msr_set(MS_RQM); in_phase = 0;
            end
            if (p < HEADER_BYTES) begin
               r.read_byte = hdr_bytes[p];
               header_reads++;
            end else begin
               r.from_disk   = 1'b1;
               r.disk_offset = base_off + OFFSET_W'(p - HEADER_BYTES);
               payload_reads++;
            end
            rpos = p + 1;
         end else begin
            r.read_byte = READ_INVALID;
         end
      end else if (kind == ACC_STATUS_READ) begin
         r.read_byte = msr;
      end
      reply_queue.push_back(r);
   endtask

   always @(posedge clock) begin
      access_reply_type want;
      if (reset) begin
         param_idx  <= 0;
         active_cmd <= CMD_NONE;
         msr        <= MS_RQM;
         unit       <= 0;
         head       <= 0;
         cyl_new    <= 0;
         cyl_present <= 0;
         sector     <= 0;
         size_n     <= 8'd2;
         st0        <= 0;
         st3        <= 0;
         busy_op    <= 0;
         timing     <= 0;
         rd_params  <= 0;
         remaining  <= 0;
         rpos       <= 0;
         in_phase   <= 0;
         base_off   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_queue.size() == 0) begin
               report("unexpected response", rsp_tdata, 32'd0);
            end else begin
               want = reply_queue.pop_front();
               if (rsp_tdata[7:0] !== want.read_byte)
                  report("read_byte", 32'(rsp_tdata[7:0]), 32'(want.read_byte));
               if (rsp_tuser !== want.from_disk)
                  report("from_disk", 32'(rsp_tuser), 32'(want.from_disk));
               if (rsp_tdata[28:8] !== want.disk_offset)
                  report("disk_offset", 32'(rsp_tdata[28:8]), 32'(want.disk_offset));
               if (rsp_tdata[31:29] !== 3'b0)
                  report("tdata padding", 32'(rsp_tdata[31:29]), 32'd0);
            end
         end
         if (req_tvalid && req_tready) predict_access(req_tuser, req_tdata);
      end
   end

   initial begin
      error_count   = 0;
      payload_reads = 0;
      header_reads  = 0;
   end

endmodule

@@ bench/fdc_command_result_controller_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_command_result_controller_unit_test
// Drives bus accesses into the floppy controller: command sequences with
// random parameters mixed with noise, under random idling on both channels.
// ----------------------------------------------------------------------------
module fdc_command_result_controller_unit_test;
   import fdccr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] write_byte
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [7:0] read_byte, [28:8] disk_offset
   logic        rsp_tuser;   // [0] from_disk
   int          error_count;
   int          pending_count;
   int          payload_reads;
   int          header_reads;
   int          request_count;
   logic        calm;

   fdc_command_result_controller_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   fdc_command_result_controller_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .error_count(error_count), .pending_count(pending_count),
      .payload_reads(payload_reads), .header_reads(header_reads)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver stalls at random except in calm stretches
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 27);
   end

   // valid stays up between back to back requests and drops only while idling
   task automatic send_access(logic [1:0] kind, logic [7:0] v);
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      request_count++;
   endtask

   task automatic write_byte(logic [7:0] v);
      send_access(ACC_DATA_WRITE, v);
   endtask

   task automatic drain_result(int count);
      repeat (count) send_access(ACC_DATA_READ, 8'($urandom));
   endtask

   task automatic random_sequence();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0: begin
            write_byte(OPC_SPECIFY); write_byte(8'($urandom)); write_byte(8'($urandom));
         end
         1: begin
            write_byte(OPC_SENSE_DRIVE); write_byte(8'($urandom));
            drain_result($urandom_range(2));
         end
         2: begin
            write_byte(OPC_RECAL); write_byte(8'($urandom));
         end
         3: begin
            write_byte(OPC_SENSE_INT); drain_result($urandom_range(3));
         end
         4: begin
            write_byte({4'($urandom_range(15)), OPC_READ_ID_LO});
            write_byte(8'($urandom));
            drain_result($urandom_range(8));
         end
         5: begin
            write_byte({4'($urandom_range(15)), OPC_READ_DATA_LO});
            repeat (8) write_byte(8'($urandom));
            // mostly short reads; sometimes the whole sector
            drain_result(($urandom_range(9) == 0) ? HEADER_BYTES + SECTOR_BYTES + 1
                                                   : $urandom_range(20));
         end
         6: begin
            write_byte(OPC_SEEK); write_byte(8'($urandom)); write_byte(8'($urandom));
         end
         7: send_access(ACC_STATUS_READ, 8'($urandom));
         8: send_access(2'd3, 8'($urandom));
         default: send_access(2'($urandom_range(3)), 8'($urandom));
      endcase
   endtask

   initial begin
      int cycles;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tuser     = ACC_DATA_WRITE;
      calm          = 1'b0;
      request_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reads before any result, unused kind, unknown opcode
      send_access(ACC_DATA_READ, 8'h00);
      send_access(ACC_STATUS_READ, 8'hFF);
      send_access(2'd3, 8'hFF);
      write_byte(8'hFF);
      write_byte(OPC_SENSE_INT);          // no pending operation
      drain_result(3);
      write_byte(OPC_SPECIFY); write_byte(8'hFF); write_byte(8'h00);
      write_byte(OPC_SENSE_DRIVE); write_byte(8'h07); drain_result(1);
      write_byte(OPC_SEEK); write_byte(8'h04); write_byte(8'hFF);
      write_byte(OPC_RECAL); write_byte(8'h03);
      write_byte(OPC_SENSE_INT); drain_result(2);
      // read data at sector 8 of track 255 wraps the cylinder
      write_byte(8'hF6);
      write_byte(8'h05); write_byte(8'hFF); write_byte(8'h01); write_byte(8'h08);
      write_byte(8'h02); write_byte(8'h12); write_byte(8'h1B); write_byte(8'hFF);
      write_byte(OPC_SENSE_INT);          // new command mid result phase
      drain_result(HEADER_BYTES + SECTOR_BYTES + 1);
      write_byte(8'h0A); write_byte(8'h00); drain_result(HEADER_BYTES);

      repeat (80) random_sequence();
      calm = 1'b1;
      repeat (40) random_sequence();
      calm = 1'b0;
      while (request_count < 1800) random_sequence();
      req_tvalid <= 1'b0;

      cycles = 0;
      while (pending_count != 0 && cycles < 10000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (5) @(posedge clock);
      $display("%0d accesses sent: %0d result header bytes and %0d payload offsets checked",
               request_count, header_reads, payload_reads);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout waiting for the controller");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/fdccr_pkg.sv
rtl/core/fdc_command_result_controller_unit.sv
bench/fdc_command_result_controller_unit_checker.sv
bench/fdc_command_result_controller_unit_test.sv
